@@ rtl/bitmap_block_allocator_top_defines.svh @@
// ----------------------------------------------------------------------------
// bitmap_block_allocator_top_defines
// assertion macros shared by the allocator rtl
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BBA_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BBA_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// shared constants, types and bit helpers of the bitmap block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int TOTAL_BLOCKS_DEF    = 1024;
  localparam int MAX_PER_REQUEST_DEF = 64;

  localparam int LEN_W    = 16;
  localparam int STATUS_W = 2;
  localparam int BLKNUM_W = 10;
  localparam int FREE_W   = 11;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int BIU_W    = 11;
  localparam int BPB_W    = 13;
  localparam int NEED_W   = 17;

  localparam logic [BIU_W-1:0] BIU_RST = 11'd1024;
  localparam logic [BPB_W-1:0] BPB_RST = 13'd64;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_BLOCK = 8'd1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd2;

  typedef struct packed {
    logic             done;
    logic [LEN_W-1:0] quot;
    logic             rem_nz;
  } div_res_t;

  function automatic logic [6:0] popcnt64(input logic [63:0] x);
    logic [6:0] c;
    c = '0;
    for (int i = 0; i < 64; i++) begin
      c = c + 7'(x[i]);
    end
    return c;
  endfunction

  // index of the lowest set bit, 0 when none is set
  function automatic logic [5:0] lsb64(input logic [63:0] x);
    logic [5:0] p;
    p = '0;
    for (int i = 63; i >= 0; i--) begin
      if (x[i]) p = 6'(i);
    end
    return p;
  endfunction

endpackage

@@ rtl/bba_if.sv @@
// ----------------------------------------------------------------------------
// bba_if
// valid/ready channels of the allocator: request, result and register write
// ----------------------------------------------------------------------------
interface bba_req_if;
  logic                        valid;
  logic                        ready;
  logic [bba_pkg::LEN_W-1:0]   content_length;
  modport source (output valid, output content_length, input ready);
  modport sink   (input valid, input content_length, output ready);
endinterface

interface bba_res_if;
  logic                           valid;
  logic                           ready;
  logic [bba_pkg::STATUS_W-1:0]   status;
  logic [bba_pkg::BLKNUM_W-1:0]   block_number;
  logic                           is_index_block;
  logic                           last;
  logic [bba_pkg::FREE_W-1:0]     free_blocks;
  modport source (output valid, output status, output block_number,
                  output is_index_block, output last, output free_blocks,
                  input ready);
  modport sink   (input valid, input status, input block_number,
                  input is_index_block, input last, input free_blocks,
                  output ready);
endinterface

interface bba_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bba_pkg::CFG_IDX_W-1:0]   idx;
  logic [bba_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

@@ rtl/bba_ram.sv @@
// ----------------------------------------------------------------------------
// bba_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/bba_div.sv @@
// ----------------------------------------------------------------------------
// bba_div
// restoring divider, one quotient bit per cycle, for request sizing
// ----------------------------------------------------------------------------
module bba_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bba_pkg::LEN_W-1:0]     dividend,
  input  logic [bba_pkg::BPB_W-1:0]     divisor,
  output bba_pkg::div_res_t             res
);
  import bba_pkg::*;

  logic [LEN_W-1:0] quo_r, quo_nxt;
  logic [BPB_W-1:0] rem_r, rem_nxt;
  logic [BPB_W-1:0] dvs_r, dvs_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [BPB_W:0]   trial;
  logic [BPB_W:0]   diff;

  always_comb begin
    trial    = {rem_r, quo_r[LEN_W-1]};
    diff     = trial - {1'b0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[BPB_W-1:0];
        quo_nxt = {quo_r[LEN_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[BPB_W-1:0];
        quo_nxt = {quo_r[LEN_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(LEN_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign res.done   = done_r;
  assign res.quot   = quo_r;
  assign res.rem_nz = (rem_r != '0);

endmodule

@@ rtl/bitmap_block_allocator_top.sv @@
// ----------------------------------------------------------------------------
// bitmap_block_allocator_top
// first-fit allocator over a used-bit map held in a word-wide ram
// ----------------------------------------------------------------------------
// Usage: a request on in_ch carries a content length in bytes. The block
// needs ceil(length / bytes_per_block) + 1 blocks and hands back one result
// per allocated block on out_ch, lowest block first, the first one flagged
// as the index block and the final one flagged last. A request that does
// not fit gives a single no_space result, one that fits but needs more than
// MAX_PER_REQUEST blocks a single too_large result.
// Registers are written on cfg_ch (index 0 blocks_in_use, index 1
// bytes_per_block); the user must write them only while no request is
// in flight, as the block does not enforce it; cfg_ch is always ready.
// Flow: one request at a time. The free count is taken by reading every
// map word once, overlapped with the divider; then each map word visited
// is read (S_READ), loaded (S_LOAD) and scanned (S_ALLOC), handing out
// its free blocks lowest first until the request is served. A single
// output register holds the current result; while out_ch stalls the scan
// waits, and the next request is taken as soon as the last result of the
// previous one sits in that register.
// Reset empties the map at once (per-word valid bits) and restores the
// register defaults.
// ----------------------------------------------------------------------------
`include "bitmap_block_allocator_top_defines.svh"

module bitmap_block_allocator_top #(
  parameter int TOTAL_BLOCKS    = bba_pkg::TOTAL_BLOCKS_DEF,
  parameter int MAX_PER_REQUEST = bba_pkg::MAX_PER_REQUEST_DEF
) (
  input logic      clk,
  input logic      rst_n,
  bba_req_if.sink  in_ch,
  bba_res_if.source out_ch,
  bba_cfg_if.sink  cfg_ch
);
  import bba_pkg::*;

  localparam int MAP_WORDS = (TOTAL_BLOCKS + 63) / 64;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int MW        = AW + 7;
  localparam int KW        = $clog2(MAX_PER_REQUEST + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_COUNT, S_DECIDE, S_READ, S_LOAD, S_ALLOC
  } state_t;

  state_t            state_r, state_nxt;
  logic [BIU_W-1:0]  biu_r, biu_nxt;
  logic [BPB_W-1:0]  bpb_r, bpb_nxt;
  logic [MAP_WORDS-1:0] vld_r, vld_nxt;
  logic [AW-1:0]     cw_r, cw_nxt;
  logic [AW-1:0]     pw_r, pw_nxt;
  logic              pend_r, pend_nxt;
  logic              iss_done_r, iss_done_nxt;
  logic [MW-1:0]     free_r, free_nxt;
  logic [NEED_W-1:0] need_r, need_nxt;
  logic [AW-1:0]     aw_r, aw_nxt;
  logic [63:0]       cur_r, cur_nxt;
  logic [KW-1:0]     k_r, k_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [BLKNUM_W-1:0] out_blk_r, out_blk_nxt;
  logic                out_idx_r, out_idx_nxt;
  logic                out_last_r, out_last_nxt;
  logic [FREE_W-1:0]   out_free_r, out_free_nxt;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_wdata, ram_rdata;

  logic          div_start;
  logic [BPB_W-1:0] div_dvs;
  div_res_t      div_res;

  logic [MW-1:0] n_managed;
  logic [63:0]   cnt_word;
  logic [63:0]   avail;
  logic [5:0]    pick;
  logic          can_emit;
  logic          emit_ok;
  logic          is_last;
  logic [AW+5:0] blk_full;

  function automatic logic [63:0] word_mask(input logic [AW-1:0] w,
                                            input logic [MW-1:0] n);
    logic [MW-1:0] base;
    logic [MW-1:0] rem;
    base = MW'({w, 6'd0});
    rem  = n - base;
    if (n >= base + MW'(64)) return '1;
    else if (n > base) return (64'd1 << rem[5:0]) - 64'd1;
    else return '0;
  endfunction

  bba_ram #(.WIDTH(64), .DEPTH(MAP_WORDS), .AW(AW)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign div_dvs = (bpb_r == '0) ? BPB_W'(1) : bpb_r;

  bba_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_ch.content_length),
    .divisor  (div_dvs),
    .res      (div_res)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.block_number   = out_blk_r;
  assign out_ch.is_index_block = out_idx_r;
  assign out_ch.last           = out_last_r;
  assign out_ch.free_blocks    = out_free_r;

  always_comb begin
    if (32'(biu_r) > 32'(TOTAL_BLOCKS)) n_managed = MW'(TOTAL_BLOCKS);
    else n_managed = MW'(biu_r);
    // never-written words read as empty
    cnt_word = vld_r[pw_r] ? ram_rdata : '0;
    avail    = ~cur_r & word_mask(aw_r, n_managed);
    pick     = lsb64(avail);
    blk_full = {aw_r, pick};
    can_emit = !out_valid_r || out_ch.ready;
    is_last  = (32'(k_r) + 32'd1 == 32'(need_r));
    emit_ok  = (state_r == S_ALLOC) && (avail != '0) && can_emit;
  end

  always_comb begin
    state_nxt    = state_r;
    biu_nxt      = biu_r;
    bpb_nxt      = bpb_r;
    vld_nxt      = vld_r;
    cw_nxt       = cw_r;
    pw_nxt       = pw_r;
    pend_nxt     = 1'b0;
    iss_done_nxt = iss_done_r;
    free_nxt     = free_r;
    need_nxt     = need_r;
    aw_nxt       = aw_r;
    cur_nxt      = cur_r;
    k_nxt        = k_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_blk_nxt    = out_blk_r;
    out_idx_nxt    = out_idx_r;
    out_last_nxt   = out_last_r;
    out_free_nxt   = out_free_r;
    ram_we    = 1'b0;
    ram_waddr = aw_r;
    ram_wdata = cur_r;
    ram_re    = 1'b0;
    ram_raddr = aw_r;
    div_start = 1'b0;

    if (cfg_ch.valid) begin
      if (cfg_ch.idx == REG_BLOCKS_IN_USE) biu_nxt = cfg_ch.data[BIU_W-1:0];
      if (cfg_ch.idx == REG_BYTES_PER_BLOCK) bpb_nxt = cfg_ch.data[BPB_W-1:0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          div_start    = 1'b1;
          cw_nxt       = '0;
          iss_done_nxt = 1'b0;
          free_nxt     = '0;
          state_nxt    = S_COUNT;
        end
      end
      S_COUNT: begin
        if (!iss_done_r) begin
          ram_re    = 1'b1;
          ram_raddr = cw_r;
          pend_nxt  = 1'b1;
          pw_nxt    = cw_r;
          if (32'(cw_r) == MAP_WORDS - 1) iss_done_nxt = 1'b1;
          else cw_nxt = cw_r + AW'(1);
        end
        if (pend_r) begin
          free_nxt = free_r + MW'(popcnt64(~cnt_word & word_mask(pw_r, n_managed)));
        end
        if (iss_done_r && !pend_r && div_res.done) begin
          need_nxt  = NEED_W'(div_res.quot) + NEED_W'(div_res.rem_nz) + NEED_W'(1);
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (32'(free_r) < 32'(need_r) || 32'(need_r) > MAX_PER_REQUEST) begin
          if (can_emit) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = (32'(free_r) < 32'(need_r)) ? ST_NO_SPACE : ST_TOO_LARGE;
            out_blk_nxt    = '0;
            out_idx_nxt    = 1'b0;
            out_last_nxt   = 1'b1;
            out_free_nxt   = FREE_W'(free_r);
            state_nxt      = S_IDLE;
          end
        end else begin
          aw_nxt    = '0;
          k_nxt     = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        ram_re    = 1'b1;
        ram_raddr = aw_r;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cur_nxt   = vld_r[aw_r] ? ram_rdata : '0;
        state_nxt = S_ALLOC;
      end
      S_ALLOC: begin
        if (avail == '0) begin
          // word exhausted: store it back and move on
          ram_we          = 1'b1;
          ram_wdata       = cur_r;
          vld_nxt[aw_r]   = 1'b1;
          aw_nxt          = aw_r + AW'(1);
          state_nxt       = S_READ;
        end else if (can_emit) begin
          cur_nxt        = cur_r | (64'd1 << pick);
          free_nxt       = free_r - MW'(1);
          k_nxt          = k_r + KW'(1);
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_blk_nxt    = BLKNUM_W'(blk_full);
          out_idx_nxt    = (k_r == '0);
          out_last_nxt   = is_last;
          out_free_nxt   = FREE_W'(free_r - MW'(1));
          if (is_last) begin
            ram_we        = 1'b1;
            ram_wdata     = cur_r | (64'd1 << pick);
            vld_nxt[aw_r] = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      biu_r       <= BIU_RST;
      bpb_r       <= BPB_RST;
      vld_r       <= '0;
      pend_r      <= 1'b0;
      iss_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cw_r        <= '0;
      aw_r        <= '0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      biu_r       <= biu_nxt;
      bpb_r       <= bpb_nxt;
      vld_r       <= vld_nxt;
      pend_r      <= pend_nxt;
      iss_done_r  <= iss_done_nxt;
      out_valid_r <= out_valid_nxt;
      cw_r        <= cw_nxt;
      aw_r        <= aw_nxt;
      k_r         <= k_nxt;
    end
    pw_r         <= pw_nxt;
    free_r       <= free_nxt;
    need_r       <= need_nxt;
    cur_r        <= cur_nxt;
    out_status_r <= out_status_nxt;
    out_blk_r    <= out_blk_nxt;
    out_idx_r    <= out_idx_nxt;
    out_last_r   <= out_last_nxt;
    out_free_r   <= out_free_nxt;
  end

  `BBA_CHK_NEXT(a_req_starts_count, in_ch.valid && in_ch.ready, state_r == S_COUNT, "request did not start the free count")
  `BBA_CHK_NOW(a_alloc_in_range, emit_ok, 32'(blk_full) < 32'(n_managed), "allocated block outside managed range")
  `BBA_CHK_NOW(a_free_bounded, state_r == S_DECIDE, free_r <= n_managed, "free count exceeds managed blocks")

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the bitmap first-fit block allocator
// ----------------------------------------------------------------------------
// Requests are queued by the stimulus process and sent by a clocked driver
// with random gaps. Every accepted request is run through a local allocation
// model that keeps its own used map and register copies and queues the
// expected results. A clocked monitor takes results under random stalls and
// compares them field by field. Registers are rewritten between phases once
// all outstanding results are back.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  localparam int NBLK       = TOTAL_BLOCKS_DEF;
  localparam int MAX_REQ    = MAX_PER_REQUEST_DEF;
  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL_WAIT  = 64;

  // unmapped register index, writes to it are ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd2;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BLKNUM_W-1:0] block_number;
    logic                is_index_block;
    logic                last;
    logic [FREE_W-1:0]   free_blocks;
  } alloc_result_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             drain;
  } pending_req_t;

  logic clk = 1'b0;
  logic rst_n;

  bba_req_if req_ch ();
  bba_res_if res_ch ();
  bba_cfg_if cfg_ch ();

  bitmap_block_allocator_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (res_ch),
    .cfg_ch (cfg_ch)
  );

  always #1 clk = ~clk;

  // allocation model state
  logic [NBLK-1:0]  used_blocks;
  logic [BIU_W-1:0] managed_reg;
  logic [BPB_W-1:0] block_bytes;

  alloc_result_t expected_allocs[$];
  pending_req_t  pending_reqs[$];

  int reqs_queued;
  int reqs_taken;
  int results_seen;
  int blocks_granted;
  int no_space_seen;
  int too_large_seen;
  int err_count;
  int send_gap;
  int stall_left;
  int idle_cycles;
  bit quiet_send;
  bit quiet_recv;

  function automatic int managed_blocks();
    return (managed_reg > NBLK) ? NBLK : int'(managed_reg);
  endfunction

  function automatic int count_free();
    int cnt;
    cnt = 0;
    for (int b = 0; b < managed_blocks(); b++) begin
      if (!used_blocks[b]) cnt++;
    end
    return cnt;
  endfunction

  function automatic int first_free();
    for (int b = 0; b < NBLK; b++) begin
      if (!used_blocks[b]) return b;
    end
    return NBLK;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void predict_allocation(input logic [LEN_W-1:0] len);
    int            unit_bytes;
    int            need;
    int            avail;
    int            n;
    int            k;
    alloc_result_t r;
    unit_bytes = (block_bytes == 0) ? 1 : int'(block_bytes);
    need       = (int'(len) + unit_bytes - 1) / unit_bytes + 1;
    avail      = count_free();
    n          = managed_blocks();
    if (avail < need || need > MAX_REQ) begin
      // no_space wins over too_large
      r.status         = (avail < need) ? ST_NO_SPACE : ST_TOO_LARGE;
      r.block_number   = '0;
      r.is_index_block = 1'b0;
      r.last           = 1'b1;
      r.free_blocks    = FREE_W'(avail);
      expected_allocs.push_back(r);
    end else begin
      k = 0;
      for (int b = 0; b < n && k < need; b++) begin
        if (!used_blocks[b]) begin
          used_blocks[b]   = 1'b1;
          avail--;
          r.status         = ST_OK;
          r.block_number   = BLKNUM_W'(b);
          r.is_index_block = (k == 0);
          r.last           = (k + 1 == need);
          r.free_blocks    = FREE_W'(avail);
          expected_allocs.push_back(r);
          k++;
        end
      end
    end
  endfunction

  // length that lands on a chosen block count, mostly small ones
  function automatic logic [LEN_W-1:0] random_length();
    int unit_bytes;
    int need;
    int len;
    int pick;
    unit_bytes = (block_bytes == 0) ? 1 : int'(block_bytes);
    pick       = $urandom_range(0, 99);
    if (pick < 10) return LEN_W'($urandom);
    if (pick < 70) need = $urandom_range(1, 6);
    else if (pick < 88) need = $urandom_range(7, MAX_REQ);
    else need = $urandom_range(MAX_REQ + 1, MAX_REQ + 40);
    if (need == 1) return '0;
    len = (need - 1) * unit_bytes - int'($urandom_range(0, unit_bytes - 1));
    return (len > 65535) ? 16'hFFFF : LEN_W'(len);
  endfunction

  task automatic push_req(input logic [LEN_W-1:0] len, input logic drain);
    pending_req_t p;
    p.len   = len;
    p.drain = drain;
    pending_reqs.push_back(p);
    reqs_queued++;
  endtask

  task automatic drain_all();
    while (reqs_taken != reqs_queued || expected_allocs.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_BLOCKS_IN_USE) managed_reg = data[BIU_W-1:0];
    else if (idx == REG_BYTES_PER_BLOCK) block_bytes = data[BPB_W-1:0];
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_result();
    alloc_result_t want;
    results_seen++;
    case (res_ch.status)
      ST_OK:        blocks_granted++;
      ST_NO_SPACE:  no_space_seen++;
      ST_TOO_LARGE: too_large_seen++;
      default: ;
    endcase
    if (expected_allocs.size() == 0) begin
      $error("unexpected result: status %0d block %0d", res_ch.status, res_ch.block_number);
      err_count++;
    end else begin
      want = expected_allocs.pop_front();
      if (res_ch.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, res_ch.status);
        err_count++;
      end
      if (res_ch.block_number !== want.block_number) begin
        $error("block_number: expected %0d, got %0d", want.block_number, res_ch.block_number);
        err_count++;
      end
      if (res_ch.is_index_block !== want.is_index_block) begin
        $error("is_index_block: expected %0d, got %0d", want.is_index_block,
               res_ch.is_index_block);
        err_count++;
      end
      if (res_ch.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, res_ch.last);
        err_count++;
      end
      if (res_ch.free_blocks !== want.free_blocks) begin
        $error("free_blocks: expected %0d, got %0d", want.free_blocks, res_ch.free_blocks);
        err_count++;
      end
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid          <= 1'b0;
      req_ch.content_length <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_allocation(req_ch.content_length);
        reqs_taken++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].drain && expected_allocs.size() > 0)) begin
          req_ch.valid          <= 1'b1;
          req_ch.content_length <= pending_reqs[0].len;
          void'(pending_reqs.pop_front());
          send_gap = quiet_send ? 0 : pick_gap();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) check_result();
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (!quiet_recv && $urandom_range(0, 5) == 0) begin
        stall_left = pick_gap();
        res_ch.ready <= (stall_left == 0);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $error("no handshake for %0d cycles, %0d results outstanding", idle_cycles,
               expected_allocs.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int ff;
    int biu;
    int bpb;
    int n_items;
    rst_n                 = 1'b0;
    req_ch.valid          = 1'b0;
    req_ch.content_length = '0;
    res_ch.ready          = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.idx            = '0;
    cfg_ch.data           = '0;
    used_blocks           = '0;
    managed_reg           = BIU_RST;
    block_bytes           = BPB_RST;
    reqs_queued           = 0;
    reqs_taken            = 0;
    results_seen          = 0;
    blocks_granted        = 0;
    no_space_seen         = 0;
    too_large_seen        = 0;
    err_count             = 0;
    send_gap              = 0;
    stall_left            = 0;
    idle_cycles           = 0;
    quiet_send            = 1'b0;
    quiet_recv            = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: sizes around one block, exactly the cap, one past it
    push_req(16'd0, 1'b0);
    push_req(16'd1, 1'b0);
    push_req(16'd64, 1'b0);
    push_req(16'd65, 1'b0);
    push_req(16'd4032, 1'b0);
    push_req(16'd4033, 1'b0);
    push_req(16'hFFFF, 1'b0);
    push_req(16'd128, 1'b1);
    drain_all();

    // zero block size acts as one byte
    write_reg(REG_BYTES_PER_BLOCK, 16'd0);
    push_req(16'd0, 1'b0);
    push_req(16'd5, 1'b0);
    push_req(16'd64, 1'b0);
    push_req(16'hFFFF, 1'b0);
    push_req(16'd63, 1'b0);
    drain_all();

    // upper data bits are dropped, leaving the largest block size
    write_reg(REG_BYTES_PER_BLOCK, 16'hFFFF);
    push_req(16'hFFFF, 1'b0);
    push_req(16'd8191, 1'b0);
    push_req(16'd8192, 1'b0);
    drain_all();

    write_reg(REG_BYTES_PER_BLOCK, 16'd4096);
    push_req(16'd4096, 1'b0);
    push_req(16'hFFFF, 1'b0);
    drain_all();

    // nothing managed
    write_reg(REG_BLOCKS_IN_USE, 16'd0);
    push_req(16'd0, 1'b0);
    push_req(16'd12345, 1'b0);
    drain_all();

    // shrunk below the used prefix, then a write to an unmapped index
    write_reg(REG_BLOCKS_IN_USE, 16'd100);
    push_req(16'd0, 1'b0);
    drain_all();
    write_reg(REG_SPARE, 16'hFFFF);
    push_req(16'd0, 1'b0);
    drain_all();

    // oversized count saturates
    write_reg(REG_BLOCKS_IN_USE, 16'hFFFF);
    push_req(16'd0, 1'b0);
    drain_all();

    // fill the managed range exactly, then one more
    write_reg(REG_BLOCKS_IN_USE, CFG_DATA_W'(first_free() + 3));
    write_reg(REG_BYTES_PER_BLOCK, 16'd64);
    push_req(16'd128, 1'b0);
    push_req(16'd0, 1'b0);
    drain_all();

    // random phases, the managed range mostly grows so new blocks keep opening up (phase 3 shrinks it)
    for (int p = 0; p < 8; p++) begin
      quiet_send = (p % 4 == 1);
      quiet_recv = (p % 4 == 2);
      ff = first_free();
      case (p)
        3:       biu = ff / 2;
        6:       biu = 1024;
        7:       biu = 2047;
        default: biu = (ff + 160 > 1024) ? 1024 : ff + int'($urandom_range(48, 160));
      endcase
      case (p)
        0:       bpb = 1;
        1:       bpb = 64;
        2:       bpb = $urandom_range(2, 4096);
        3:       bpb = 8191;
        4:       bpb = 0;
        5:       bpb = 512;
        6:       bpb = 4096;
        default: bpb = $urandom_range(1, 8191);
      endcase
      write_reg(REG_BLOCKS_IN_USE, CFG_DATA_W'(biu));
      write_reg(REG_BYTES_PER_BLOCK, CFG_DATA_W'(bpb));
      n_items = (p == 3) ? 15 : 52;
      for (int i = 0; i < n_items; i++) begin
        push_req(random_length(), $urandom_range(0, 29) == 0);
      end
      drain_all();
    end

    repeat (TAIL_WAIT) @(posedge clk);

    $display("%0d requests, %0d results: %0d blocks granted, %0d no_space, %0d too_large",
             reqs_taken, results_seen, blocks_granted, no_space_seen, too_large_seen);
    $display("block counts 0 to 2047 and block sizes 0 to 8191 used, %0d blocks taken at end",
             first_free());
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
